### sv/wavhdr_pkg.sv
package wavhdr_pkg;

  // parse phases
  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_RSIZE = 3'd1;
  localparam logic [2:0] PH_WAVE  = 3'd2;
  localparam logic [2:0] PH_ID    = 3'd3;
  localparam logic [2:0] PH_SIZE  = 3'd4;
  localparam logic [2:0] PH_FMT   = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  // four-character tags as seen after little-endian assembly
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY     = 32'd16;
  localparam logic [4:0]  FMT_LAST_IDX = 5'd15;
  localparam logic [4:0]  WORD_LAST_IDX = 5'd3;
  localparam logic [15:0] BITS_8       = 16'd8;
  localparam logic [15:0] BITS_16      = 16'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;
  localparam logic [15:0] CHANNELS_MONO = 16'd1;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF      = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE      = 3'd2;
  localparam logic [2:0] ST_CHUNK_MISSING = 3'd3;
  localparam logic [2:0] ST_NOT_PCM       = 3'd4;
  localparam logic [2:0] ST_UNSUP_BITS    = 3'd5;

  // format codes
  localparam logic [1:0] FC_MONO8    = 2'd0;
  localparam logic [1:0] FC_STEREO8  = 2'd1;
  localparam logic [1:0] FC_MONO16   = 2'd2;
  localparam logic [1:0] FC_STEREO16 = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [31:0] data_size;
    logic [31:0] data_offset;
  } wavhdr_result_t;

endpackage

### sv/wavhdr_core.sv
module wavhdr_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [7:0]                 file_byte,
  input  logic                       end_of_file,
  output logic                       emit,
  output wavhdr_pkg::wavhdr_result_t result
);

  logic [2:0]  phase, phase_next;
  logic [4:0]  idx, idx_next;
  logic [31:0] pos, pos_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] word_shift, word_shift_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic [31:0] size_seen, size_seen_next;
  logic [31:0] offset_seen, offset_seen_next;
  logic        fmt_seen, fmt_seen_next;
  logic        data_seen, data_seen_next;
  logic        reported, reported_next;

  logic [2:0]  emit_status;
  logic [1:0]  emit_code;
  logic [2:0]  final_status;
  logic [1:0]  final_code;
  logic        hit_final;
  logic        hit_error;
  logic [2:0]  error_status;

  // verdict on the captured fmt fields, taken from the updated values
  always_comb begin
    final_status = wavhdr_pkg::ST_UNSUP_BITS;
    final_code   = wavhdr_pkg::FC_MONO8;
    if (format_tag_next != wavhdr_pkg::FORMAT_PCM) begin
      final_status = wavhdr_pkg::ST_NOT_PCM;
    end else if (sample_bits_next == wavhdr_pkg::BITS_8) begin
      final_status = wavhdr_pkg::ST_OK;
      final_code   = (channel_count_next == wavhdr_pkg::CHANNELS_MONO) ?
                     wavhdr_pkg::FC_MONO8 : wavhdr_pkg::FC_STEREO8;
    end else if (sample_bits_next == wavhdr_pkg::BITS_16) begin
      final_status = wavhdr_pkg::ST_OK;
      final_code   = (channel_count_next == wavhdr_pkg::CHANNELS_MONO) ?
                     wavhdr_pkg::FC_MONO16 : wavhdr_pkg::FC_STEREO16;
    end
  end

  always_comb begin
    phase_next         = phase;
    idx_next           = idx;
    remaining_next     = remaining;
    tag_shift_next     = tag_shift;
    word_shift_next    = word_shift;
    format_tag_next    = format_tag;
    channel_count_next = channel_count;
    rate_seen_next     = rate_seen;
    sample_bits_next   = sample_bits;
    size_seen_next     = size_seen;
    offset_seen_next   = offset_seen;
    fmt_seen_next      = fmt_seen;
    data_seen_next     = data_seen;
    hit_final          = 1'b0;
    hit_error          = 1'b0;
    error_status       = wavhdr_pkg::ST_CHUNK_MISSING;

    unique case (phase)
      wavhdr_pkg::PH_RIFF, wavhdr_pkg::PH_WAVE, wavhdr_pkg::PH_ID: begin
        tag_shift_next = {file_byte, tag_shift[31:8]};
        idx_next       = idx + 5'd1;
        if (idx == wavhdr_pkg::WORD_LAST_IDX) begin
          idx_next = '0;
          if (phase == wavhdr_pkg::PH_RIFF) begin
            if (tag_shift_next != wavhdr_pkg::TAG_RIFF) begin
              hit_error    = 1'b1;
              error_status = wavhdr_pkg::ST_NOT_RIFF;
            end else begin
              phase_next = wavhdr_pkg::PH_RSIZE;
            end
          end else if (phase == wavhdr_pkg::PH_WAVE) begin
            if (tag_shift_next != wavhdr_pkg::TAG_WAVE) begin
              hit_error    = 1'b1;
              error_status = wavhdr_pkg::ST_NOT_WAVE;
            end else begin
              phase_next = wavhdr_pkg::PH_ID;
            end
          end else begin
            phase_next = wavhdr_pkg::PH_SIZE;
          end
        end
      end
      wavhdr_pkg::PH_RSIZE: begin
        idx_next = idx + 5'd1;
        if (idx == wavhdr_pkg::WORD_LAST_IDX) begin
          idx_next   = '0;
          phase_next = wavhdr_pkg::PH_WAVE;
        end
      end
      wavhdr_pkg::PH_SIZE: begin
        word_shift_next = {file_byte, word_shift[31:8]};
        idx_next        = idx + 5'd1;
        if (idx == wavhdr_pkg::WORD_LAST_IDX) begin
          idx_next = '0;
          if (tag_shift == wavhdr_pkg::TAG_FMT) begin
            if (word_shift_next < wavhdr_pkg::FMT_BODY) begin
              hit_error    = 1'b1;
              error_status = wavhdr_pkg::ST_CHUNK_MISSING;
            end else begin
              remaining_next = word_shift_next - wavhdr_pkg::FMT_BODY;
              phase_next     = wavhdr_pkg::PH_FMT;
            end
          end else begin
            if (tag_shift == wavhdr_pkg::TAG_DATA) begin
              size_seen_next   = word_shift_next;
              offset_seen_next = pos + 32'd1;
              data_seen_next   = 1'b1;
            end
            if (tag_shift == wavhdr_pkg::TAG_DATA && fmt_seen) begin
              hit_final = 1'b1;
            end else begin
              remaining_next = word_shift_next;
              phase_next     = (word_shift_next == '0) ? wavhdr_pkg::PH_ID :
                               wavhdr_pkg::PH_SKIP;
            end
          end
        end
      end
      wavhdr_pkg::PH_FMT: begin
        unique case (idx)
          5'd0:  format_tag_next[7:0]     = file_byte;
          5'd1:  format_tag_next[15:8]    = file_byte;
          5'd2:  channel_count_next[7:0]  = file_byte;
          5'd3:  channel_count_next[15:8] = file_byte;
          5'd4:  rate_seen_next[7:0]      = file_byte;
          5'd5:  rate_seen_next[15:8]     = file_byte;
          5'd6:  rate_seen_next[23:16]    = file_byte;
          5'd7:  rate_seen_next[31:24]    = file_byte;
          5'd14: sample_bits_next[7:0]    = file_byte;
          5'd15: sample_bits_next[15:8]   = file_byte;
          default: ;
        endcase
        idx_next = idx + 5'd1;
        if (idx == wavhdr_pkg::FMT_LAST_IDX) begin
          idx_next      = '0;
          fmt_seen_next = 1'b1;
          if (data_seen) begin
            hit_final = 1'b1;
          end else begin
            phase_next = (remaining == '0) ? wavhdr_pkg::PH_ID : wavhdr_pkg::PH_SKIP;
          end
        end
      end
      wavhdr_pkg::PH_SKIP: begin
        remaining_next = remaining - 32'd1;
        if (remaining_next == '0) begin
          phase_next = wavhdr_pkg::PH_ID;
        end
      end
      wavhdr_pkg::PH_DONE: ;
      default: ;
    endcase

    pos_next      = pos + 32'd1;
    reported_next = reported;
    emit          = 1'b0;
    emit_status   = error_status;
    emit_code     = wavhdr_pkg::FC_MONO8;

    priority if (hit_final) begin
      emit        = 1'b1;
      emit_status = final_status;
      emit_code   = final_code;
    end else if (hit_error) begin
      emit        = 1'b1;
    end else if (end_of_file && !reported) begin
      // file ended before a verdict
      emit = 1'b1;
      if (phase_next == wavhdr_pkg::PH_RIFF) begin
        emit_status = wavhdr_pkg::ST_NOT_RIFF;
      end else if (phase_next == wavhdr_pkg::PH_RSIZE ||
                   phase_next == wavhdr_pkg::PH_WAVE) begin
        emit_status = wavhdr_pkg::ST_NOT_WAVE;
      end else begin
        emit_status = wavhdr_pkg::ST_CHUNK_MISSING;
      end
    end
    if (hit_final || hit_error) begin
      reported_next = 1'b1;
      phase_next    = wavhdr_pkg::PH_DONE;
    end
  end

  assign result.status      = emit_status;
  assign result.format_code = emit_code;
  assign result.sample_rate = rate_seen_next;
  assign result.data_size   = size_seen_next;
  assign result.data_offset = offset_seen_next;

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      phase         <= wavhdr_pkg::PH_RIFF;
      idx           <= '0;
      pos           <= '0;
      remaining     <= '0;
      tag_shift     <= '0;
      word_shift    <= '0;
      format_tag    <= '0;
      channel_count <= '0;
      rate_seen     <= '0;
      sample_bits   <= '0;
      size_seen     <= '0;
      offset_seen   <= '0;
      fmt_seen      <= 1'b0;
      data_seen     <= 1'b0;
      reported      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      idx           <= idx_next;
      pos           <= pos_next;
      remaining     <= remaining_next;
      tag_shift     <= tag_shift_next;
      word_shift    <= word_shift_next;
      format_tag    <= format_tag_next;
      channel_count <= channel_count_next;
      rate_seen     <= rate_seen_next;
      sample_bits   <= sample_bits_next;
      size_seen     <= size_seen_next;
      offset_seen   <= offset_seen_next;
      fmt_seen      <= fmt_seen_next;
      data_seen     <= data_seen_next;
      reported      <= reported_next;
    end
  end

  a_reported_done: assert property (@(posedge clk) disable iff (rst)
    reported == (phase == wavhdr_pkg::PH_DONE))
    else $error("reported flag and done phase disagree");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (phase != wavhdr_pkg::PH_FMT) |-> (idx <= wavhdr_pkg::WORD_LAST_IDX))
    else $error("field index out of range outside fmt body");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == wavhdr_pkg::PH_SKIP) |-> (remaining != '0))
    else $error("skip phase with nothing left to skip");

endmodule

### sv/wav_riff_header_parser.sv
// a byte is held in the input register and its result, if any, in the output register
// throughput: one byte per cycle while the output is not stalled; the whole per-byte
// update is one pass of the core logic. A result waiting in the output register holds
// the byte in the input register, so the input stalls as soon as that register is full
// rst is synchronous, active high, and clears all parse state and both valid flags
// after the end-of-file byte the parser returns to its reset state on its own
module wav_riff_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  format_code,
  output logic [31:0] sample_rate,
  output logic [31:0] data_size,
  output logic [31:0] data_offset
);

  logic                       held_valid;
  logic [7:0]                 held_byte;
  logic                       held_eof;
  logic                       advance;
  logic                       emit;
  wavhdr_pkg::wavhdr_result_t result;

  // held request moves into the core when the result slot can take it
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= file_byte;
      held_eof  <= end_of_file;
    end
  end

  wavhdr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .file_byte   (held_byte),
    .end_of_file (held_eof),
    .emit        (emit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      status      <= result.status;
      format_code <= result.format_code;
      sample_rate <= result.sample_rate;
      data_size   <= result.data_size;
      data_offset <= result.data_offset;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (held_valid && out_valid && !out_ready) |=> held_valid)
    else $error("held request lost while result stalled");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != wavhdr_pkg::ST_OK) |-> (format_code == wavhdr_pkg::FC_MONO8))
    else $error("format code set on an error result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(data_offset) && $stable(status))
    else $error("pending result overwritten");

endmodule
